### src/wvaf_pkg.sv
package wvaf_pkg;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_STEPS_PER_REV = 2'd0,
    REG_WINDOW_TICKS  = 2'd1,
    REG_SPEED_SCALE   = 2'd2,
    REG_MPH_FACTOR    = 2'd3
  } cfg_reg_e;

  // register values after reset
  localparam logic [7:0]  StepsPerRevRst = 8'd76;
  localparam logic [15:0] WindowTicksRst = 16'd1000;
  localparam logic [15:0] SpeedScaleRst  = 16'd44473;
  localparam logic [13:0] MphFactorRst   = 14'd9163;

  // fixed output ranges
  localparam logic [15:0] LatchPulseMax = 16'd1023;
  localparam logic [23:0] SpeedMsMax    = 24'd262143;

  // vane movement for one quadrature transition
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_e;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_GO,
    S_RED_WAIT,
    S_STEP,
    S_BIN_GO,
    S_BIN_WAIT,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_DONE
  } ctl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic take_item;
    logic div_start;
    logic div_bin;
    logic take_rem;
    logic step;
    logic take_bin;
    logic mul1;
    logic mul2;
    logic mul3;
    logic load_out;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pos_ge_mod;
    logic div_done;
    logic win;
    logic out_free;
  } ctl_status_t;

  // gray-code transition table, index is {previous, current}
  function automatic step_e quad_step(input logic [3:0] idx);
    step_e res;
    unique case (idx)
      4'b0001, 4'b0111, 4'b1000, 4'b1110: res = STEP_UP;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: res = STEP_DOWN;
      default:                            res = STEP_NONE;
    endcase
    return res;
  endfunction

endpackage

### src/wvaf_div.sv
module wvaf_div #(
  parameter int NUM_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [8:0]       den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [8:0]       rem_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [8:0]       rem_q;
  logic [8:0]       den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [10:0]      trial;
  logic             borrow;
  logic [8:0]       rem_step;

  // one restoring step: shift in the next dividend bit and try the subtract
  assign trial    = {1'b0, rem_q, num_q[NUM_W-1]} - {2'b00, den_q};
  assign borrow   = trial[10];
  assign rem_step = borrow ? {rem_q[7:0], num_q[NUM_W-1]} : trial[8:0];

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= 9'd0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ~borrow};
      rem_q <= rem_step;
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(NUM_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

### src/wvaf_dp.sv
module wvaf_dp #(
  parameter int DIRECTION_BINS   = 8,
  parameter int PULSE_COUNT_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item fields
  input  logic                  vane_a_i,
  input  logic                  vane_b_i,
  input  logic                  anemo_level_i,
  input  logic                  ms_tick_i,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  // result
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            vane_step_o,
  output logic [2:0]            direction_index_o,
  output logic [9:0]            window_pulses_o,
  output logic [17:0]           speed_ms_o,
  output logic [19:0]           speed_mph_o,
  output logic                  window_done_o,
  // controller link
  input  wvaf_pkg::ctl_cmd_t    cmd_i,
  output wvaf_pkg::ctl_status_t status_o
);

  localparam int BinBits = $clog2(DIRECTION_BINS);
  localparam int NumW    = 8 + BinBits;
  localparam logic [PULSE_COUNT_BITS-1:0] PulseMax = '1;

  // configuration registers
  logic [7:0]  spr_q;
  logic [15:0] win_ticks_q;
  logic [15:0] scale_q;
  logic [13:0] factor_q;

  // captured item
  logic [1:0]  item_quad_q;
  logic        item_anemo_q;
  logic        item_tick_q;

  // sensor state
  logic [1:0]                  prev_quad_q;
  logic                        seeded_q;
  logic [7:0]                  pos_q;
  logic                        prev_anemo_q;
  logic [PULSE_COUNT_BITS-1:0] pulse_q;
  logic [15:0]                 tick_q;
  logic                        win_q;
  logic [15:0]                 snap_q;
  logic [9:0]                  lat_pulses_q;
  logic [17:0]                 lat_ms_q;
  logic [19:0]                 lat_mph_q;
  logic [2:0]                  bin_q;

  // speed products
  logic [31:0] prod1_q;
  logic [31:0] prod2_q;

  // result register
  logic        out_valid_q;
  logic        out_valid_d;
  logic [7:0]  out_step_q;
  logic [2:0]  out_dir_q;
  logic [9:0]  out_pulses_q;
  logic [17:0] out_ms_q;
  logic [19:0] out_mph_q;
  logic        out_done_q;

  logic [8:0]                  modulus;
  logic [8:0]                  mod_m1;
  logic [8:0]                  pos_inc;
  logic [7:0]                  pos_step;
  wvaf_pkg::step_e             step_dir;
  logic [PULSE_COUNT_BITS-1:0] pulse_next;
  logic [15:0]                 tick_next;
  logic                        win_next;
  logic [15:0]                 snap_next;
  logic [NumW-1:0]             div_num;
  logic                        div_done;
  logic [NumW-1:0]             div_quo;
  logic [8:0]                  div_rem;
  logic [23:0]                 ms_raw;
  logic [17:0]                 ms_sat;

  // a zero modulus register means a full 256-step revolution
  assign modulus = (spr_q == 8'd0) ? 9'd256 : {1'b0, spr_q};
  assign mod_m1  = modulus - 9'd1;
  assign pos_inc = {1'b0, pos_q} + 9'd1;

  // position step, only once the previous quadrature state is known
  assign step_dir = wvaf_pkg::quad_step({prev_quad_q, item_quad_q});
  always_comb begin
    pos_step = pos_q;
    if (seeded_q) begin
      unique case (step_dir)
        wvaf_pkg::STEP_UP:   pos_step = (pos_inc >= modulus) ? 8'd0 : pos_inc[7:0];
        wvaf_pkg::STEP_DOWN: pos_step = (pos_q == 8'd0) ? mod_m1[7:0] : pos_q - 8'd1;
        default:             pos_step = pos_q;
      endcase
    end
  end

  // falling-edge pulse count and millisecond count, both saturating
  assign pulse_next = (prev_anemo_q && !item_anemo_q && (pulse_q != PulseMax)) ?
                      pulse_q + PULSE_COUNT_BITS'(1) : pulse_q;
  assign tick_next  = (item_tick_q && (tick_q != 16'hFFFF)) ? tick_q + 16'd1 : tick_q;
  assign win_next   = (tick_next >= win_ticks_q);
  assign snap_next  = 16'(pulse_next);

  // shared divider: position reduction or compass bin
  assign div_num = cmd_i.div_bin ? NumW'(pos_q) * NumW'(DIRECTION_BINS) : NumW'(pos_q);

  wvaf_div #(
    .NUM_W (NumW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (modulus),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // m/s saturation ahead of the mph multiply
  assign ms_raw = prod1_q[31:8];
  assign ms_sat = (ms_raw > wvaf_pkg::SpeedMsMax) ? 18'h3FFFF : ms_raw[17:0];

  // configuration writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q       <= wvaf_pkg::StepsPerRevRst;
      win_ticks_q <= wvaf_pkg::WindowTicksRst;
      scale_q     <= wvaf_pkg::SpeedScaleRst;
      factor_q    <= wvaf_pkg::MphFactorRst;
    end else if (cfg_valid_i) begin
      unique case (wvaf_pkg::cfg_reg_e'(cfg_index_i))
        wvaf_pkg::REG_STEPS_PER_REV: spr_q       <= cfg_data_i[7:0];
        wvaf_pkg::REG_WINDOW_TICKS:  win_ticks_q <= cfg_data_i;
        wvaf_pkg::REG_SPEED_SCALE:   scale_q     <= cfg_data_i;
        wvaf_pkg::REG_MPH_FACTOR:    factor_q    <= cfg_data_i[13:0];
        default:                     spr_q       <= spr_q;
      endcase
    end
  end

  // item capture and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      item_quad_q  <= {vane_a_i, vane_b_i};
      item_anemo_q <= anemo_level_i;
      item_tick_q  <= ms_tick_i;
    end
    if (cmd_i.take_bin) begin
      bin_q <= div_quo[2:0];
    end
    if (cmd_i.step) begin
      snap_q <= snap_next;
    end
    if (cmd_i.mul1) begin
      prod1_q <= {16'd0, snap_q} * {16'd0, scale_q};
    end
    if (cmd_i.mul2) begin
      prod2_q <= {14'd0, ms_sat} * {18'd0, factor_q};
    end
  end

  // sensor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_quad_q  <= 2'd0;
      seeded_q     <= 1'b0;
      pos_q        <= 8'd0;
      prev_anemo_q <= 1'b1;
      pulse_q      <= '0;
      tick_q       <= 16'd0;
      win_q        <= 1'b0;
      lat_pulses_q <= 10'd0;
      lat_ms_q     <= 18'd0;
      lat_mph_q    <= 20'd0;
    end else begin
      if (cmd_i.take_rem) begin
        pos_q <= div_rem[7:0];
      end
      if (cmd_i.step) begin
        pos_q        <= pos_step;
        prev_quad_q  <= item_quad_q;
        seeded_q     <= 1'b1;
        prev_anemo_q <= item_anemo_q;
        win_q        <= win_next;
        if (win_next) begin
          pulse_q      <= '0;
          tick_q       <= 16'd0;
          lat_pulses_q <= (snap_next > wvaf_pkg::LatchPulseMax) ?
                          wvaf_pkg::LatchPulseMax[9:0] : snap_next[9:0];
        end else begin
          pulse_q <= pulse_next;
          tick_q  <= tick_next;
        end
      end
      if (cmd_i.mul2) begin
        lat_ms_q <= ms_sat;
      end
      if (cmd_i.mul3) begin
        lat_mph_q <= prod2_q[31:12];
      end
    end
  end

  // result register, frees up once the result is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_step_q   <= pos_q;
      out_dir_q    <= bin_q;
      out_pulses_q <= lat_pulses_q;
      out_ms_q     <= lat_ms_q;
      out_mph_q    <= lat_mph_q;
      out_done_q   <= win_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign vane_step_o       = out_step_q;
  assign direction_index_o = out_dir_q;
  assign window_pulses_o   = out_pulses_q;
  assign speed_ms_o        = out_ms_q;
  assign speed_mph_o       = out_mph_q;
  assign window_done_o     = out_done_q;

  // status to the controller
  assign status_o.pos_ge_mod = ({1'b0, pos_q} >= modulus);
  assign status_o.div_done   = div_done;
  assign status_o.win        = win_q;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

### src/wvaf_ctrl.sv
module wvaf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output wvaf_pkg::ctl_cmd_t    cmd_o,
  input  wvaf_pkg::ctl_status_t status_i
);

  wvaf_pkg::ctl_state_e state_q;
  wvaf_pkg::ctl_state_e state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wvaf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.pos_ge_mod ? wvaf_pkg::S_RED_GO : wvaf_pkg::S_STEP;
        end
      end
      wvaf_pkg::S_RED_GO:   state_d = wvaf_pkg::S_RED_WAIT;
      wvaf_pkg::S_RED_WAIT: begin
        if (status_i.div_done) begin
          state_d = wvaf_pkg::S_STEP;
        end
      end
      wvaf_pkg::S_STEP:     state_d = wvaf_pkg::S_BIN_GO;
      wvaf_pkg::S_BIN_GO:   state_d = wvaf_pkg::S_BIN_WAIT;
      wvaf_pkg::S_BIN_WAIT: begin
        if (status_i.div_done) begin
          state_d = status_i.win ? wvaf_pkg::S_MUL1 : wvaf_pkg::S_DONE;
        end
      end
      wvaf_pkg::S_MUL1:     state_d = wvaf_pkg::S_MUL2;
      wvaf_pkg::S_MUL2:     state_d = wvaf_pkg::S_MUL3;
      wvaf_pkg::S_MUL3:     state_d = wvaf_pkg::S_DONE;
      wvaf_pkg::S_DONE: begin
        if (status_i.out_free) begin
          state_d = wvaf_pkg::S_IDLE;
        end
      end
      default:              state_d = wvaf_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      wvaf_pkg::S_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.take_item = in_valid_i;
      end
      wvaf_pkg::S_RED_GO:   cmd_o.div_start = 1'b1;
      wvaf_pkg::S_RED_WAIT: cmd_o.take_rem  = status_i.div_done;
      wvaf_pkg::S_STEP:     cmd_o.step      = 1'b1;
      wvaf_pkg::S_BIN_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_bin   = 1'b1;
      end
      wvaf_pkg::S_BIN_WAIT: cmd_o.take_bin  = status_i.div_done;
      wvaf_pkg::S_MUL1:     cmd_o.mul1      = 1'b1;
      wvaf_pkg::S_MUL2:     cmd_o.mul2      = 1'b1;
      wvaf_pkg::S_MUL3:     cmd_o.mul3      = 1'b1;
      wvaf_pkg::S_DONE:     cmd_o.load_out  = status_i.out_free;
      default:              cmd_o           = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wvaf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/wind_vane_and_anemometer_frontend_unit.sv
// Wind vane and anemometer front end. Each item is one sample of the two vane
// quadrature pins, the anemometer pin and a millisecond tick flag, and gives one
// result: wrapped vane position, compass bin, and the pulse count and speeds
// latched at the last window end, with window_done set on the item that closed
// a window. On the first item after reset the vane does not move, as the item
// only seeds the quadrature state. Each item goes through the shared restoring
// divider, which forms the compass bin, and no new item is taken until the last
// one is loaded into the output register. An item that closes a window also
// passes through S_MUL1, S_MUL2 and S_MUL3 for the two speed multiplies, and the
// first item after a steps_per_rev write that leaves the position out of range
// takes a reduction pass through the same divider first. The next item is taken
// while the previous result waits in the output register. Configuration must be
// written only while the block is idle; the block itself does not enforce this,
// and the write port is always ready.
module wind_vane_and_anemometer_frontend_unit #(
  parameter int DIRECTION_BINS   = 8,
  parameter int PULSE_COUNT_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        vane_a_i,
  input  logic        vane_b_i,
  input  logic        anemo_level_i,
  input  logic        ms_tick_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  vane_step_o,
  output logic [2:0]  direction_index_o,
  output logic [9:0]  window_pulses_o,
  output logic [17:0] speed_ms_o,
  output logic [19:0] speed_mph_o,
  output logic        window_done_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  wvaf_pkg::ctl_cmd_t    cmd;
  wvaf_pkg::ctl_status_t status;

  wvaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  wvaf_dp #(
    .DIRECTION_BINS   (DIRECTION_BINS),
    .PULSE_COUNT_BITS (PULSE_COUNT_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .vane_a_i          (vane_a_i),
    .vane_b_i          (vane_b_i),
    .anemo_level_i     (anemo_level_i),
    .ms_tick_i         (ms_tick_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .vane_step_o       (vane_step_o),
    .direction_index_o (direction_index_o),
    .window_pulses_o   (window_pulses_o),
    .speed_ms_o        (speed_ms_o),
    .speed_mph_o       (speed_mph_o),
    .window_done_o     (window_done_o),
    .cmd_i             (cmd),
    .status_o          (status)
  );

endmodule

### src/wvaf_checker.sv
module wvaf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  vane_step_o,
  input logic [2:0]  direction_index_o,
  input logic [9:0]  window_pulses_o,
  input logic [17:0] speed_ms_o,
  input logic [19:0] speed_mph_o,
  input logic        window_done_o
);

  // an accepted item keeps the block busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted but block free on the next cycle");

  // a new result only appears out of work in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no item in progress");

  // mph factor is below four, so mph never exceeds four times m/s
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({2'b00, speed_mph_o} <= {2'b00, speed_ms_o, 2'b00}))
    else $error("mph speed out of line with m/s speed");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(vane_step_o)
      && $stable(direction_index_o) && $stable(window_pulses_o)
      && $stable(speed_ms_o) && $stable(speed_mph_o) && $stable(window_done_o))
    else $error("stalled result changed");

endmodule

bind wind_vane_and_anemometer_frontend_unit wvaf_checker u_wvaf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .vane_step_o       (vane_step_o),
  .direction_index_o (direction_index_o),
  .window_pulses_o   (window_pulses_o),
  .speed_ms_o        (speed_ms_o),
  .speed_mph_o       (speed_mph_o),
  .window_done_o     (window_done_o)
);

### dv/tb_wind_vane_and_anemometer_frontend_unit.sv
`timescale 1ns / 1ps

module tb_wind_vane_and_anemometer_frontend_unit;

  localparam int DIR_BINS = 8;
  localparam int PULSE_BITS = 10;
  localparam logic [9:0] PULSE_CAP = 10'((1 << PULSE_BITS) - 1);
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 64;
  localparam int SAT_EDGES = 1024;
  localparam int PHASE_ITEMS = 25;

  // one reading as it leaves the block
  typedef struct packed {
    logic [7:0]  vane_step;
    logic [2:0]  direction_index;
    logic [9:0]  window_pulses;
    logic [17:0] speed_ms;
    logic [19:0] speed_mph;
    logic        window_done;
  } wind_reading_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        vane_a_i;
  logic        vane_b_i;
  logic        anemo_level_i;
  logic        ms_tick_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  vane_step_o;
  logic [2:0]  direction_index_o;
  logic [9:0]  window_pulses_o;
  logic [17:0] speed_ms_o;
  logic [19:0] speed_mph_o;
  logic        window_done_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // register mirror
  logic [7:0]  cfg_steps;
  logic [15:0] cfg_window;
  logic [15:0] cfg_scale;
  logic [13:0] cfg_factor;

  // sensor state mirror
  logic [1:0]  vane_prev_quad;
  logic        vane_seeded;
  logic [7:0]  vane_pos;
  logic        anemo_prev;
  logic [9:0]  pulse_count;
  logic [15:0] tick_count;
  logic [9:0]  held_pulses;
  logic [17:0] held_ms;
  logic [19:0] held_mph;

  wind_reading_t pending_readings[$];
  logic [1:0]    last_quad;
  int            send_idle_pct;
  int            stall_pct;
  logic          hold_off_req;
  int            mismatch_count;
  int            samples_sent;
  int            readings_checked;
  int            windows_closed;

  wind_vane_and_anemometer_frontend_unit #(
    .DIRECTION_BINS  (DIR_BINS),
    .PULSE_COUNT_BITS(PULSE_BITS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .vane_a_i         (vane_a_i),
    .vane_b_i         (vane_b_i),
    .anemo_level_i    (anemo_level_i),
    .ms_tick_i        (ms_tick_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .vane_step_o      (vane_step_o),
    .direction_index_o(direction_index_o),
    .window_pulses_o  (window_pulses_o),
    .speed_ms_o       (speed_ms_o),
    .speed_mph_o      (speed_mph_o),
    .window_done_o    (window_done_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver stall, with an occasional long hold-off
  initial begin
    int hold_count;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
        hold_off_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // gray code position of a quadrature state, moved and turned back to pin levels
  function automatic logic [1:0] quad_after(input logic [1:0] quad, input int move);
    logic [1:0] idx;
    idx = {quad[1], quad[1] ^ quad[0]};
    idx = idx + 2'(move);
    return {idx[1], idx[1] ^ idx[0]};
  endfunction

  // vane and anemometer behavior for one sample
  function automatic wind_reading_t predict_wind_sample(input logic [1:0] quad,
                                                        input logic lvl,
                                                        input logic tick);
    wind_reading_t    r;
    int unsigned      modulus;
    int unsigned      pos;
    logic [1:0]       prev_idx;
    logic [1:0]       cur_idx;
    logic [1:0]       delta;
    longint unsigned  ms_full;
    longint unsigned  mph_full;
    modulus = (cfg_steps == 8'd0) ? 256 : cfg_steps;
    pos = vane_pos % modulus;
    // quadrature step, double jumps and repeats do not move
    if (vane_seeded) begin
      prev_idx = {vane_prev_quad[1], vane_prev_quad[1] ^ vane_prev_quad[0]};
      cur_idx = {quad[1], quad[1] ^ quad[0]};
      delta = cur_idx - prev_idx;
      if (delta == 2'd1) begin
        pos = (pos + 1 >= modulus) ? 0 : pos + 1;
      end else if (delta == 2'd3) begin
        pos = (pos == 0) ? modulus - 1 : pos - 1;
      end
    end
    vane_pos = 8'(pos);
    vane_prev_quad = quad;
    vane_seeded = 1'b1;
    r.vane_step = 8'(pos);
    r.direction_index = 3'((pos * DIR_BINS) / modulus);
    // falling edge count, saturating
    if (anemo_prev && !lvl && pulse_count < PULSE_CAP) begin
      pulse_count = pulse_count + 1'b1;
    end
    anemo_prev = lvl;
    // window close latches the speeds
    if (tick && tick_count != 16'hFFFF) begin
      tick_count = tick_count + 1'b1;
    end
    r.window_done = 1'b0;
    if (tick_count >= cfg_window) begin
      ms_full = pulse_count;
      ms_full = (ms_full * cfg_scale) >> 8;
      if (ms_full > 64'd262143) begin
        ms_full = 64'd262143;
      end
      mph_full = (ms_full * cfg_factor) >> 12;
      if (mph_full > 64'd1048575) begin
        mph_full = 64'd1048575;
      end
      held_pulses = pulse_count;
      held_ms = 18'(ms_full);
      held_mph = 20'(mph_full);
      pulse_count = '0;
      tick_count = '0;
      r.window_done = 1'b1;
    end
    r.window_pulses = held_pulses;
    r.speed_ms = held_ms;
    r.speed_mph = held_mph;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] reading %0d: %s got %0d want %0d", $realtime, readings_checked,
             what, got, want);
    mismatch_count++;
  endtask

  // compare each accepted reading with the oldest prediction
  always @(negedge clk_i) begin
    wind_reading_t got;
    wind_reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {vane_step_o, direction_index_o, window_pulses_o, speed_ms_o, speed_mph_o,
             window_done_o};
      if (pending_readings.size() == 0) begin
        report_mismatch("reading with none pending", 1, 0);
      end else begin
        want = pending_readings.pop_front();
        if (got.vane_step !== want.vane_step)
          report_mismatch("vane_step", got.vane_step, want.vane_step);
        if (got.direction_index !== want.direction_index)
          report_mismatch("direction_index", got.direction_index, want.direction_index);
        if (got.window_pulses !== want.window_pulses)
          report_mismatch("window_pulses", got.window_pulses, want.window_pulses);
        if (got.speed_ms !== want.speed_ms)
          report_mismatch("speed_ms", got.speed_ms, want.speed_ms);
        if (got.speed_mph !== want.speed_mph)
          report_mismatch("speed_mph", got.speed_mph, want.speed_mph);
        if (got.window_done !== want.window_done)
          report_mismatch("window_done", got.window_done, want.window_done);
        if (want.window_done) begin
          windows_closed++;
        end
      end
      readings_checked++;
    end
  end

  // offer one sample, predict it once taken, then maybe idle
  task automatic send_item(input logic [1:0] quad, input logic lvl, input logic tick);
    logic taken;
    in_valid_i <= 1'b1;
    vane_a_i <= quad[1];
    vane_b_i <= quad[0];
    anemo_level_i <= lvl;
    ms_tick_i <= tick;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    pending_readings.push_back(predict_wind_sample(quad, lvl, tick));
    last_quad = quad;
    samples_sent++;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // mostly legal vane rotation, some repeats, double jumps and random states
  task automatic send_walk_item(input logic lvl, input logic tick);
    int r;
    logic [1:0] quad;
    r = $urandom_range(99);
    if (r < 38) quad = quad_after(last_quad, 1);
    else if (r < 76) quad = quad_after(last_quad, -1);
    else if (r < 88) quad = last_quad;
    else if (r < 94) quad = quad_after(last_quad, 2);
    else quad = 2'($urandom_range(3));
    send_item(quad, lvl, tick);
  endtask

  task automatic write_register(input wvaf_pkg::cfg_reg_e idx, input logic [15:0] value);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    unique case (idx)
      wvaf_pkg::REG_STEPS_PER_REV: cfg_steps = value[7:0];
      wvaf_pkg::REG_WINDOW_TICKS:  cfg_window = value;
      wvaf_pkg::REG_SPEED_SCALE:   cfg_scale = value;
      wvaf_pkg::REG_MPH_FACTOR:    cfg_factor = value[13:0];
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering and let every pending reading come out
  task automatic wait_for_readings();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_all_registers(input logic [7:0] steps, input logic [15:0] window,
                                     input logic [15:0] scale, input logic [13:0] factor);
    write_register(wvaf_pkg::REG_STEPS_PER_REV, {8'd0, steps});
    write_register(wvaf_pkg::REG_WINDOW_TICKS, window);
    write_register(wvaf_pkg::REG_SPEED_SCALE, scale);
    write_register(wvaf_pkg::REG_MPH_FACTOR, {2'd0, factor});
  endtask

  // every quadrature transition once, with reset register values
  task automatic test_gray_transitions();
    logic [1:0] walk[17] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
                             2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};
    // first sample seeds only, and its low level is an edge from the idle high
    for (int i = 0; i < 17; i++) begin
      send_item(walk[i], i[0], (i % 3) == 0);
    end
    wait_for_readings();
  endtask

  // modulus one, modulus zero wrapping to 255, and top modulus
  task automatic test_modulus_corners();
    write_all_registers(8'd1, 16'd0, 16'hFFFF, 14'h3FFF);
    send_item(quad_after(last_quad, 1), 1'b1, 1'b0);
    send_item(quad_after(last_quad, -1), 1'b0, 1'b1);
    wait_for_readings();
    write_register(wvaf_pkg::REG_STEPS_PER_REV, 16'd0);
    send_item(quad_after(last_quad, -1), 1'b1, 1'b0);
    send_item(quad_after(last_quad, -1), 1'b0, 1'b1);
    wait_for_readings();
    write_register(wvaf_pkg::REG_STEPS_PER_REV, 16'd255);
    write_register(wvaf_pkg::REG_WINDOW_TICKS, 16'd1);
    send_item(quad_after(last_quad, 1), 1'b1, 1'b1);
    send_item(quad_after(last_quad, 1), 1'b0, 1'b1);
    wait_for_readings();
  endtask

  // receiver holds off while samples keep coming, so the input backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    write_all_registers(8'd16, 16'd2, 16'd30000, 14'd9163);
    hold_off_req = 1'b1;
    repeat (24) send_walk_item(1'($urandom_range(1)), 1'($urandom_range(1)));
    wait_for_readings();
  endtask

  // long window with a falling edge every other sample
  task automatic test_pulse_saturation();
    send_idle_pct = 0;
    stall_pct = 0;
    write_all_registers(8'd37, 16'hFFFF, 16'hFFFF, 14'h3FFF);
    for (int i = 0; i < 2 * SAT_EDGES; i++) begin
      send_walk_item(~i[0], 1'b0);
    end
    wait_for_readings();
    // close the window with one tick
    write_register(wvaf_pkg::REG_WINDOW_TICKS, 16'd1);
    send_walk_item(1'b1, 1'b1);
    wait_for_readings();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input logic [7:0] steps,
                                   input logic [15:0] window, input logic [15:0] scale,
                                   input logic [13:0] factor);
    send_idle_pct = idle;
    stall_pct = stall;
    write_all_registers(steps, window, scale, factor);
    repeat (PHASE_ITEMS) begin
      send_walk_item(1'($urandom_range(1)), $urandom_range(99) < 50);
    end
    wait_for_readings();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    vane_a_i = 1'b0;
    vane_b_i = 1'b0;
    anemo_level_i = 1'b1;
    ms_tick_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = wvaf_pkg::REG_STEPS_PER_REV;
    cfg_data_i = '0;
    hold_off_req = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    samples_sent = 0;
    readings_checked = 0;
    windows_closed = 0;
    last_quad = 2'd0;
    // mirror of the reset state
    cfg_steps = wvaf_pkg::StepsPerRevRst;
    cfg_window = wvaf_pkg::WindowTicksRst;
    cfg_scale = wvaf_pkg::SpeedScaleRst;
    cfg_factor = wvaf_pkg::MphFactorRst;
    vane_prev_quad = '0;
    vane_seeded = 1'b0;
    vane_pos = '0;
    anemo_prev = 1'b1;
    pulse_count = '0;
    tick_count = '0;
    held_pulses = '0;
    held_ms = '0;
    held_mph = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_gray_transitions();
    test_modulus_corners();
    test_backpressure();
    test_pulse_saturation();
    test_random_phase(0, 0, 8'd2, 16'd2, 16'($urandom), 14'($urandom));
    test_random_phase(61, 0, 8'($urandom_range(3, 254)), 16'($urandom_range(1, 8)),
                      16'($urandom), 14'($urandom));
    test_random_phase(0, 61, 8'd255, 16'd1, 16'd1, 14'd1);
    test_random_phase(21, 21, 8'd0, 16'd5, 16'($urandom), 14'($urandom));

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("sent %0d vane/anemometer samples, checked %0d readings, %0d window closes",
             samples_sent, readings_checked, windows_closed);
    $display("covered all gray transitions, modulus 0/1/2/255, pulse saturation, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/wvaf_pkg.sv
src/wvaf_div.sv
src/wvaf_dp.sv
src/wvaf_ctrl.sv
src/wind_vane_and_anemometer_frontend_unit.sv
src/wvaf_checker.sv
dv/tb_wind_vane_and_anemometer_frontend_unit.sv
